// ----- hw/rtl/ssin_pkg.sv -----
// ----------------------------------------------------------------------------
// ssin_pkg: shared constants for the smoothed sine oscillator
// Register indexes, reset values, field widths and the series divisors used
// to build the quarter-wave sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package ssin_pkg;

  // default sizing
  localparam int unsigned DefSineTableDepth = 1024;
  localparam int unsigned DefPhaseBits      = 32;

  // field widths
  localparam int unsigned TargetW = 23;
  localparam int unsigned AmpW    = 15;
  localparam int unsigned RetainW = 16;
  localparam int unsigned FreqW   = 31;
  localparam int unsigned SampleW = 16;
  localparam int unsigned EntryW  = 31;

  // configuration port
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgAddrW-1:0] CfgAmplitude   = 1'd0;
  localparam logic [CfgAddrW-1:0] CfgGlideRetain = 1'd1;

  // reset values
  localparam logic [AmpW-1:0]    AmpReset    = 15'd32000;
  localparam logic [RetainW-1:0] RetainReset = 16'd62259;
  localparam logic [FreqW-1:0]   FreqReset   = 31'd28835840;

  // arithmetic constants
  localparam longint unsigned SampleRate = 64'd44100;
  localparam longint unsigned HalfPiQ30  = 64'd1686629713;
  localparam longint unsigned OneQ30     = 64'd1073741824;

  // taylor series divisors (2n)(2n+1) for n = 1..8
  localparam longint unsigned TaylorDiv [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

endpackage

`default_nettype wire

// ----- hw/rtl/ssin_rom.sv -----
// ----------------------------------------------------------------------------
// ssin_rom: quarter-wave sine table
// Holds sin(pi/2 * k/depth) in Q1.30 for k = 0..depth, built at elaboration
// from a fixed-point series; synchronous read with a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module ssin_rom #(
  parameter int unsigned SineTableDepth = ssin_pkg::DefSineTableDepth
) (
  input  wire logic                                clk_i,
  input  wire logic [$clog2(SineTableDepth):0]     addr_i,
  output logic      [ssin_pkg::EntryW-1:0]         data_o
);

  typedef logic [ssin_pkg::EntryW-1:0] rom_t [SineTableDepth+1];

  // series evaluation of the quarter sine, one entry per table index
  function automatic rom_t build_rom();
    rom_t              t;
    logic [63:0]       ang;
    logic [63:0]       sq;
    logic [63:0]       term;
    logic signed [63:0] sum;
    for (int k = 0; k <= SineTableDepth; k++) begin
      ang  = (64'(k) * ssin_pkg::HalfPiQ30) / 64'(SineTableDepth);
      sq   = (ang * ang) >> 30;
      term = ang;
      sum  = $signed(ang);
      for (int n = 0; n < 8; n++) begin
        term = (term * sq) >> 30;
        term = term / ssin_pkg::TaylorDiv[n];
        if ((n % 2) == 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      if (sum > $signed(ssin_pkg::OneQ30)) begin
        sum = $signed(ssin_pkg::OneQ30);
      end
      t[k] = sum[ssin_pkg::EntryW-1:0];
    end
    return t;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [ssin_pkg::EntryW-1:0] data_q;

  // registered read
  always_ff @(posedge clk_i) begin
    data_q <= SineRom[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/smoothed_sine_oscillator_core.sv -----
// ----------------------------------------------------------------------------
// smoothed_sine_oscillator_core: sine tone generator with frequency glide
// Phase accumulator oscillator reading a quarter-wave table, with a one-pole
// glide of the tone frequency applied at the start of each buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Each word on the slave stream asks for one audio sample. tdata carries the
//   target frequency (Q15.8 Hz), tuser[0] marks the first sample of a buffer.
//   One signed 16-bit sample leaves on the master stream per input word.
//   A plain sample passes table read, amplitude multiply, rounding and the
//   hand-off to the output register before the next word is accepted; the
//   sample is valid on the master stream once it is in that register.
//   A buffer start adds the glide multiply and accumulate, then a digit step
//   and a remainder step per 16-bit quotient digit of the division of the
//   smoothed frequency by 44100 that yields the new phase increment.
//   The multiplier is shared between the glide and the amplitude scaling.
//   The sine table depth must be a power of two.
//   Reset sets the frequency to 440 Hz, the phase to zero, amplitude 32000
//   and glide retain 62259; the table is a constant ROM, no fill is needed.
//   A finished sample waits in the output register while the next word is
//   taken; if the receiver stalls, the core holds its next result until the
//   output register is free. Write configuration only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module smoothed_sine_oscillator_core #(
  parameter int unsigned SineTableDepth = ssin_pkg::DefSineTableDepth,
  parameter int unsigned PhaseBits      = ssin_pkg::DefPhaseBits
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [ssin_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire logic [ssin_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // request stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [23:0]                     s_axis_tdata,  // [22:0] target_freq
  input  wire logic [0:0]                      s_axis_tuser,  // [0] block_start
  // sample stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [15:0]                          m_axis_tdata   // [15:0] sample
);

  localparam int unsigned AddrW  = $clog2(SineTableDepth);
  localparam int unsigned Shift  = PhaseBits - 16;
  localparam int unsigned DigW   = 16;
  localparam int unsigned NumDig = (PhaseBits + 16 + DigW - 1) / DigW;
  localparam int unsigned NumW   = NumDig * DigW;
  localparam int unsigned CntW   = $clog2(NumDig);
  localparam int unsigned MulAW  = 33;
  localparam int unsigned MulBW  = 17;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned RemW   = DigW;
  // x / 44100 = (x >> 2) / 11025; exact reciprocal for 30-bit x, scaled 2^44
  localparam longint unsigned RateQuarter = ssin_pkg::SampleRate / 4;
  localparam longint unsigned RecipQ44    = ((64'd1 << 44) + RateQuarter - 1) / RateQuarter;
  localparam int unsigned RecipW     = 31;
  localparam int unsigned RecipProdW = 30 + RecipW;
  localparam logic [63:0] IncReset64 =
    ((64'(ssin_pkg::FreqReset) << Shift) + (ssin_pkg::SampleRate / 2)) / ssin_pkg::SampleRate;

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StMag   = 8'b00000010,
    StRnd   = 8'b00000100,
    StGlide = 8'b00001000,
    StGacc  = 8'b00010000,
    StDiv   = 8'b00100000,
    StRem   = 8'b01000000,
    StOut   = 8'b10000000
  } state_e;

  state_e                          state_q, state_d;
  logic [ssin_pkg::AmpW-1:0]       amp_q;
  logic [ssin_pkg::RetainW-1:0]    retain_q;
  logic [ssin_pkg::FreqW-1:0]      freq_q, freq_d;
  logic [PhaseBits-1:0]            phase_q;
  logic [PhaseBits-1:0]            inc_q, inc_d;
  logic [ssin_pkg::TargetW-1:0]    tgt_q;
  logic                            start_q;
  logic signed [ProdW-1:0]         prod_q;
  logic [ssin_pkg::SampleW-1:0]    sample_q, sample_d;
  logic [NumW-1:0]                 num_q, num_d;
  logic [RemW-1:0]                 rem_q, rem_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [DigW-1:0]                 quo_q;
  logic                            out_valid_q;
  logic [ssin_pkg::SampleW-1:0]    out_data_q;

  logic                            in_acc;
  logic                            out_free;
  logic [1:0]                      quad;
  logic [AddrW-1:0]                off;
  logic [AddrW:0]                  rom_addr;
  logic [ssin_pkg::EntryW-1:0]     rom_data;
  logic signed [MulAW-1:0]         mul_a;
  logic signed [MulBW-1:0]         mul_b;
  logic [31:0]                     freq_diff;
  logic [ssin_pkg::FreqW-1:0]      tgt_q15;
  logic signed [ProdW-1:0]         glide_acc;
  logic [45:0]                     mag_sum;
  logic [ssin_pkg::SampleW-1:0]    mag;
  logic [2*DigW-1:0]               div_x;
  logic [RecipProdW-1:0]           recip_prod;
  logic [DigW-1:0]                 quo_dig;
  logic [2*DigW-1:0]               quo_times_rate;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle);

  // table address from the top bits of the phase, mirrored in odd quadrants
  assign quad     = phase_q[PhaseBits-1 -: 2];
  assign off      = phase_q[PhaseBits-3 -: AddrW];
  assign rom_addr = quad[0] ? ((AddrW+1)'(SineTableDepth) - {1'b0, off}) : {1'b0, off};

  ssin_rom #(
    .SineTableDepth(SineTableDepth)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // shared multiplier operands: glide difference or amplitude scaling
  assign tgt_q15   = {tgt_q, 8'd0};
  assign freq_diff = {1'b0, freq_q} - {1'b0, tgt_q15};
  always_comb begin
    if (state_q == StGlide) begin
      mul_a = $signed({freq_diff[31], freq_diff});
      mul_b = $signed({1'b0, retain_q});
    end else begin
      mul_a = $signed({2'b00, rom_data});
      mul_b = $signed({2'b00, amp_q});
    end
  end

  // glide accumulate: target*65536 + (freq - target)*retain + half
  assign glide_acc = $signed(ProdW'({tgt_q15, 16'd0})) + prod_q + $signed(ProdW'(32768));
  assign freq_d    = glide_acc[46:16];

  // amplitude rounding and sign from the quadrant
  assign mag_sum  = prod_q[45:0] + 46'(64'd1 << 29);
  assign mag      = mag_sum[45:30];
  assign sample_d = quad[1] ? (16'd0 - mag) : mag;

  // long division by the sample rate, one 16-bit quotient digit per pass:
  // digit from a reciprocal multiply, remainder from multiply and subtract
  assign div_x          = {rem_q, num_q[NumW-1 -: DigW]};
  assign recip_prod     = RecipProdW'(div_x[2*DigW-1:2]) * RecipProdW'(RecipQ44[RecipW-1:0]);
  assign quo_dig        = recip_prod[44 +: DigW];
  assign quo_times_rate = (2*DigW)'(quo_q) * (2*DigW)'(ssin_pkg::SampleRate);
  assign rem_d          = RemW'(div_x - quo_times_rate);

  // sequencer and division datapath
  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    cnt_d   = cnt_q;
    inc_d   = inc_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StMag;
        end
      end
      StMag: begin
        state_d = StRnd;
      end
      StRnd: begin
        state_d = start_q ? StGlide : StOut;
      end
      StGlide: begin
        state_d = StGacc;
      end
      StGacc: begin
        num_d   = (NumW'(freq_d) << Shift) + NumW'(ssin_pkg::SampleRate / 2);
        cnt_d   = CntW'(NumDig - 1);
        state_d = StDiv;
      end
      StDiv: begin
        state_d = StRem;
      end
      StRem: begin
        num_d = {num_q[NumW-DigW-1:0], quo_q};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          inc_d   = num_d[PhaseBits-1:0];
          state_d = StOut;
        end else begin
          state_d = StDiv;
        end
      end
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state and oscillator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      amp_q       <= ssin_pkg::AmpReset;
      retain_q    <= ssin_pkg::RetainReset;
      freq_q      <= ssin_pkg::FreqReset;
      phase_q     <= '0;
      inc_q       <= IncReset64[PhaseBits-1:0];
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inc_q   <= inc_d;
      // register writes
      if (cfg_we_i) begin
        if (cfg_addr_i == ssin_pkg::CfgAmplitude) begin
          amp_q <= cfg_wdata_i[ssin_pkg::AmpW-1:0];
        end else if (cfg_addr_i == ssin_pkg::CfgGlideRetain) begin
          retain_q <= cfg_wdata_i[ssin_pkg::RetainW-1:0];
        end
      end
      if (state_q == StGacc) begin
        freq_q <= freq_d;
      end
      // phase advances as the sample is handed to the output register
      if ((state_q == StOut) && out_free) begin
        phase_q <= phase_q + inc_q;
      end
      if ((state_q == StOut) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tgt_q   <= s_axis_tdata[ssin_pkg::TargetW-1:0];
      start_q <= s_axis_tuser[0];
    end
    if ((state_q == StMag) || (state_q == StGlide)) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == StRnd) begin
      sample_q <= sample_d;
    end
    if (state_q == StGacc) begin
      rem_q <= '0;
    end else if (state_q == StRem) begin
      rem_q <= rem_d;
    end
    if (state_q == StDiv) begin
      quo_q <= quo_dig;
    end
    num_q <= num_d;
    cnt_q <= cnt_d;
    if ((state_q == StOut) && out_free) begin
      out_data_q <= sample_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the smoothed sine oscillator core
// Streams frequency request words with random gaps and output stalls, keeps
// its own bit-exact copy of the glide, phase step and quarter-wave lookup,
// and compares every sample word against it in order. A short directed
// table comes first, then buffers of random length over several register
// settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SineDepth  = ssin_pkg::DefSineTableDepth;
  localparam int unsigned IdlePct    = 38;
  localparam int unsigned SettleCyc  = 80;
  localparam int unsigned PhaseItems = 250;
  localparam logic [22:0] NyquistQ8  = 23'd5644800;
  localparam logic [22:0] TargetMax  = 23'h7FFFFF;

  typedef enum logic {RowWord, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e                       kind;
    logic [ssin_pkg::CfgAddrW-1:0]   addr;
    logic [ssin_pkg::CfgDataW-1:0]   data;
    logic [ssin_pkg::TargetW-1:0]    target;
    logic                            start;
    logic                            has_want;
    logic [ssin_pkg::SampleW-1:0]    want;
  } stim_row_t;

  // directed rows: word rows carry target and buffer start, cfg rows a write
  localparam stim_row_t DirectedRows [21] = '{
    // zero phase after reset gives a zero sample
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     23'd0,       1'b0, 1'b1, 16'd0},
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     23'd0,       1'b0, 1'b0, 16'd0},
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     TargetMax,   1'b1, 1'b0, 16'd0},
    '{RowCfg,  ssin_pkg::CfgAmplitude,   16'd32767, 23'd0,       1'b0, 1'b0, 16'd0},
    '{RowCfg,  ssin_pkg::CfgGlideRetain, 16'd0,     23'd0,       1'b0, 1'b0, 16'd0},
    // zero retain jumps to 11025 Hz: quarter cycle per sample, all quadrants
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     23'd2822400, 1'b1, 1'b0, 16'd0},
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     23'h555555,  1'b0, 1'b0, 16'd0},
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     23'h2AAAAA,  1'b0, 1'b0, 16'd0},
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     TargetMax,   1'b0, 1'b0, 16'd0},
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     NyquistQ8,   1'b1, 1'b0, 16'd0},
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     23'd0,       1'b0, 1'b0, 16'd0},
    // target above nyquist aliases
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     TargetMax,   1'b1, 1'b0, 16'd0},
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     23'd0,       1'b1, 1'b0, 16'd0},
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     23'd0,       1'b0, 1'b0, 16'd0},
    '{RowCfg,  ssin_pkg::CfgAmplitude,   16'd0,     23'd0,       1'b0, 1'b0, 16'd0},
    // zero amplitude silences the tone
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     23'h2AAAAA,  1'b1, 1'b1, 16'd0},
    // top bit of the amplitude write is dropped
    '{RowCfg,  ssin_pkg::CfgAmplitude,   16'hFFFF,  23'd0,       1'b0, 1'b0, 16'd0},
    '{RowCfg,  ssin_pkg::CfgGlideRetain, 16'hFFFF,  23'd0,       1'b0, 1'b0, 16'd0},
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     23'd0,       1'b1, 1'b0, 16'd0},
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     TargetMax,   1'b1, 1'b0, 16'd0},
    '{RowWord, ssin_pkg::CfgAmplitude,   16'd0,     NyquistQ8,   1'b0, 1'b0, 16'd0}
  };

  // clock, reset and block inputs
  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [ssin_pkg::CfgAddrW-1:0]   cfg_addr_i    = '0;
  logic [ssin_pkg::CfgDataW-1:0]   cfg_wdata_i   = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [23:0]                     s_axis_tdata  = '0;  // [22:0] target_freq
  logic [0:0]                      s_axis_tuser  = '0;  // [0] block_start
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [15:0]                     m_axis_tdata;        // [15:0] sample

  // oscillator copy kept by the bench
  longint unsigned                 quarter_sine [SineDepth+1];
  logic [ssin_pkg::FreqW-1:0]      freq_q16    = ssin_pkg::FreqReset;
  logic [31:0]                     phase_frac  = '0;
  logic [ssin_pkg::AmpW-1:0]       amp_level   = ssin_pkg::AmpReset;
  logic [ssin_pkg::RetainW-1:0]    retain_q16  = ssin_pkg::RetainReset;

  logic [ssin_pkg::SampleW-1:0]    pending_samples [$];
  logic [ssin_pkg::SampleW-1:0]    want_sample;
  int unsigned                     mismatch_count = 0;
  logic                            calm = 1'b0;

  smoothed_sine_oscillator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5ns clk_i = ~clk_i;

  // quarter-wave table from the taylor series in q30 radians
  initial begin
    longint unsigned ang;
    longint unsigned sq;
    longint unsigned term;
    longint          sum;
    for (int k = 0; k <= SineDepth; k++) begin
      ang  = (64'(k) * ssin_pkg::HalfPiQ30) / SineDepth;
      sq   = (ang * ang) >> 30;
      term = ang;
      sum  = longint'(ang);
      for (int n = 1; n <= 8; n++) begin
        term = (term * sq) >> 30;
        term = term / ssin_pkg::TaylorDiv[n-1];
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ssin_pkg::OneQ30)) sum = longint'(ssin_pkg::OneQ30);
      quarter_sine[k] = 64'(sum);
    end
  end

  // one sample: glide on buffer start, table lookup, then phase advance
  function automatic logic [ssin_pkg::SampleW-1:0] advance_oscillator(
      logic [ssin_pkg::TargetW-1:0] tgt, logic st);
    longint unsigned acc;
    longint unsigned step;
    longint unsigned idx;
    longint unsigned off;
    longint unsigned entry;
    longint unsigned mag;
    logic [1:0]      quad;
    if (st) begin
      acc = 64'(freq_q16) * 64'(retain_q16)
          + (64'(tgt) << 8) * (64'd65536 - 64'(retain_q16)) + 64'd32768;
      freq_q16 = ssin_pkg::FreqW'(acc >> 16);
    end
    step  = ((64'(freq_q16) << 16) + ssin_pkg::SampleRate / 2) / ssin_pkg::SampleRate;
    idx   = (64'(phase_frac) * 4 * SineDepth) >> 32;
    quad  = 2'(idx / SineDepth);
    off   = idx % SineDepth;
    entry = quad[0] ? quarter_sine[SineDepth - off] : quarter_sine[off];
    mag   = (64'(amp_level) * entry + (64'd1 << 29)) >> 30;
    phase_frac = 32'(64'(phase_frac) + step);
    return quad[1] ? ssin_pkg::SampleW'(-mag) : ssin_pkg::SampleW'(mag);
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (mismatch_count < 40) begin
      $display("%0t mismatch on %s: got %0d want %0d", $realtime, what,
               $signed(got), $signed(want));
    end
    mismatch_count++;
  endtask

  // one request word, with a random gap in front unless the run is calm
  task automatic send_word(logic [ssin_pkg::TargetW-1:0] tgt, logic st, logic has_want,
                           logic [ssin_pkg::SampleW-1:0] want);
    logic [ssin_pkg::SampleW-1:0] predicted;
    while (!calm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 24'($urandom);
      s_axis_tuser  <= 1'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, tgt};
    s_axis_tuser  <= st;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = advance_oscillator(tgt, st);
    pending_samples.push_back(has_want ? want : predicted);
  endtask

  // register write once every sample is out and the core has gone quiet
  task automatic write_register(logic [ssin_pkg::CfgAddrW-1:0] addr,
                                logic [ssin_pkg::CfgDataW-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    case (addr)
      ssin_pkg::CfgAmplitude:   amp_level  = data[ssin_pkg::AmpW-1:0];
      ssin_pkg::CfgGlideRetain: retain_q16 = data;
      default: ;
    endcase
  endtask

  // output side stalls at random, except in the calm phase
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
  end

  // in-order sample check
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected sample word", m_axis_tdata, '0);
      end else begin
        want_sample = pending_samples.pop_front();
        if (m_axis_tdata !== want_sample) begin
          report_mismatch("sample", m_axis_tdata, want_sample);
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [ssin_pkg::CfgDataW-1:0] amp_set;
    logic [ssin_pkg::CfgDataW-1:0] retain_set;
    logic [ssin_pkg::TargetW-1:0]  tgt;
    int unsigned                   sent;
    int unsigned                   run_len;
    int unsigned                   roll;
    logic                          broken;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DirectedRows[i]) begin
      if (DirectedRows[i].kind == RowCfg) begin
        write_register(DirectedRows[i].addr, DirectedRows[i].data);
      end else begin
        send_word(DirectedRows[i].target, DirectedRows[i].start,
                  DirectedRows[i].has_want, DirectedRows[i].want);
      end
    end

    // random buffers over several register settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin amp_set = 16'd32767; retain_set = 16'd0; end
        1: begin amp_set = 16'd1; retain_set = 16'd65535; end
        3: begin amp_set = 16'd32767; retain_set = 16'd65535; end
        5: begin amp_set = 16'd0; retain_set = 16'($urandom_range(0, 65535)); end
        6: begin
          amp_set    = 16'($urandom_range(0, 65535));
          retain_set = ssin_pkg::RetainReset;
        end
        default: begin
          amp_set    = 16'($urandom_range(0, 65535));
          retain_set = 16'($urandom_range(0, 65535));
        end
      endcase
      write_register(ssin_pkg::CfgAmplitude, amp_set);
      write_register(ssin_pkg::CfgGlideRetain, retain_set);
      calm <= (ph == 3);
      sent = 0;
      while (sent < PhaseItems) begin
        run_len = $urandom_range(1, 24);
        // a few runs lack the buffer start word
        broken  = ($urandom_range(9) == 0);
        roll    = $urandom_range(99);
        if (roll < 70) begin
          tgt = 23'($urandom_range(0, NyquistQ8));
        end else if (roll < 85) begin
          tgt = 23'($urandom_range(0, 51200));
        end else if (roll < 95) begin
          tgt = 23'($urandom_range(0, TargetMax));
        end else begin
          case ($urandom_range(2))
            0:       tgt = '0;
            1:       tgt = NyquistQ8;
            default: tgt = TargetMax;
          endcase
        end
        for (int j = 0; j < run_len && sent < PhaseItems; j++) begin
          send_word((j == 0) ? tgt : 23'($urandom_range(0, TargetMax)),
                    (j == 0) && !broken, 1'b0, '0);
          sent++;
        end
      end
    end

    // drain and finish
    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
